[rtl/core/texture_texel_fetch_core_defines.svh]
// ----------------------------------------------------------------------------
// Texel fetch core assertion macros
// Shared concurrent assertion forms, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXTURE_TEXEL_FETCH_CORE_DEFINES_SVH
`define TEXTURE_TEXEL_FETCH_CORE_DEFINES_SVH

// Same-cycle implication.
`define TTF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TTF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ttf_pkg.sv]
// ----------------------------------------------------------------------------
// Texel fetch package
// Field widths, register indexes, reset values and result status codes.
// ----------------------------------------------------------------------------
package ttf_pkg;

    localparam int TEX_BYTES_DEF = 65536;

    localparam int POS_W    = 24;
    localparam int WADDR_W  = 16;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam int SIZE_W   = 13;
    localparam int STRIDE_W = 16;
    localparam int BPT_W    = 3;
    localparam int IMG_W    = 17;
    localparam int MODE_W   = 2;

    // Address arithmetic: y*stride + x*bpt stays below 2^30, plus bpt.
    localparam int ADDR_W   = 31;
    localparam int COORD_W  = 48;
    localparam int MUL_A_W  = 33;
    localparam int MUL_B_W  = 24;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UV_SCALE        = 3'd0,
        CFG_ADDRESS_MODE    = 3'd1,
        CFG_TEX_WIDTH       = 3'd2,
        CFG_TEX_HEIGHT      = 3'd3,
        CFG_ROW_STRIDE      = 3'd4,
        CFG_BYTES_PER_TEXEL = 3'd5,
        CFG_IMAGE_BYTES     = 3'd6
    } cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FETCH  = 2'd0,
        ST_TRANSP = 2'd1,
        ST_MISS   = 2'd2,
        ST_WRITE  = 2'd3
    } status_t;

    localparam logic [MODE_W-1:0] AM_CLAMP  = 2'd0;
    localparam logic [MODE_W-1:0] AM_REPEAT = 2'd1;

    localparam logic [POS_W-1:0]    UV_SCALE_RST  = 24'd65536;
    localparam logic [MODE_W-1:0]   MODE_RST      = AM_CLAMP;
    localparam logic [SIZE_W-1:0]   WIDTH_RST     = 13'd256;
    localparam logic [SIZE_W-1:0]   HEIGHT_RST    = 13'd256;
    localparam logic [STRIDE_W-1:0] STRIDE_RST    = 16'd1024;
    localparam logic [BPT_W-1:0]    BPT_RST       = 3'd4;
    localparam logic [IMG_W-1:0]    IMG_BYTES_RST = 17'd65536;

    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

endpackage

[rtl/core/ttf_in_if.sv]
// ----------------------------------------------------------------------------
// Texel fetch input channel
// Valid/ready channel carrying one write or sample request per beat.
// ----------------------------------------------------------------------------
interface ttf_in_if;
    import ttf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [WADDR_W-1:0]        write_addr;
    logic [BYTE_W-1:0]         write_byte;
    logic signed [POS_W-1:0]   pos_u;
    logic signed [POS_W-1:0]   pos_v;

    modport source (output valid, op, write_addr, write_byte, pos_u, pos_v, input ready);
    modport sink   (input valid, op, write_addr, write_byte, pos_u, pos_v, output ready);
endinterface

[rtl/core/ttf_out_if.sv]
// ----------------------------------------------------------------------------
// Texel fetch result channel
// Valid/ready channel carrying one status and RGBA texel per beat.
// ----------------------------------------------------------------------------
interface ttf_out_if;
    import ttf_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   red;
    logic [BYTE_W-1:0]   green;
    logic [BYTE_W-1:0]   blue;
    logic [BYTE_W-1:0]   alpha;

    modport source (output valid, status, red, green, blue, alpha, input ready);
    modport sink   (input valid, status, red, green, blue, alpha, output ready);
endinterface

[rtl/core/ttf_mul.sv]
// ----------------------------------------------------------------------------
// Texel fetch shared multiplier
// Signed 33x24 multiplier with a registered product, reused for every step.
// ----------------------------------------------------------------------------
module ttf_mul (
    input  logic                                 clk,
    input  logic signed [ttf_pkg::MUL_A_W-1:0]   a,
    input  logic signed [ttf_pkg::MUL_B_W-1:0]   b,
    output logic signed [ttf_pkg::PROD_W-1:0]    prod_reg
);
    import ttf_pkg::*;

    logic signed [PROD_W-1:0] prod_next;

    always_comb
    begin
        prod_next = PROD_W'(a) * PROD_W'(b);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end
endmodule

[rtl/core/ttf_store.sv]
// ----------------------------------------------------------------------------
// Texel fetch byte store
// Byte-wide texture memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ttf_store #(
    parameter int DEPTH = ttf_pkg::TEX_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [ttf_pkg::BYTE_W-1:0]   wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [ttf_pkg::BYTE_W-1:0]   rd_data_reg
);
    import ttf_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end
endmodule

[rtl/core/texture_texel_fetch_core.sv]
// A write goes straight from acceptance to the done state; a sample runs the multiply steps
// and ends at the X multiply step if transparent, at the address check on a miss or zero-byte
// texel, or after its last byte read on a fetch. One item at a time: a new item is taken once
// the previous result is registered. Five products on the one shared multiplier and one byte
// per cycle from the byte-wide store set the sample time. Reset clears the sequencer and output
// valid and loads the register defaults; store contents stay undefined until written.
`include "texture_texel_fetch_core_defines.svh"

// ----------------------------------------------------------------------------
// Texture texel fetch core
// Nearest-neighbor sampler with clamp/repeat addressing over a byte store.
// ----------------------------------------------------------------------------
module texture_texel_fetch_core #(
    parameter int TEX_BYTES = ttf_pkg::TEX_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ttf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ttf_pkg::CFG_DATA_W-1:0]   cfg_data,
    ttf_in_if.sink                           item,
    ttf_out_if.source                        result
);
    import ttf_pkg::*;

    localparam int AW = $clog2(TEX_BYTES);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_MUL_U   = 12'b0000_0000_0010,
        S_MUL_V   = 12'b0000_0000_0100,
        S_MUL_X   = 12'b0000_0000_1000,
        S_MUL_Y   = 12'b0000_0001_0000,
        S_CAP_Y   = 12'b0000_0010_0000,
        S_MUL_ROW = 12'b0000_0100_0000,
        S_ADDR    = 12'b0000_1000_0000,
        S_CHECK   = 12'b0001_0000_0000,
        S_READ    = 12'b0010_0000_0000,
        S_LAST    = 12'b0100_0000_0000,
        S_DONE    = 12'b1000_0000_0000
    } state_t;

    // Configuration registers
    logic signed [POS_W-1:0] uv_scale_reg;
    logic [MODE_W-1:0]       mode_reg;
    logic [SIZE_W-1:0]       width_reg;
    logic [SIZE_W-1:0]       height_reg;
    logic [STRIDE_W-1:0]     stride_reg;
    logic [BPT_W-1:0]        bpt_reg;
    logic [IMG_W-1:0]        img_bytes_reg;

    // Control
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   pend_reg, pend_next;

    // Payload
    logic signed [POS_W-1:0]   pos_u_reg, pos_v_reg;
    logic signed [COORD_W-1:0] u_reg, v_reg;
    logic [SIZE_W-1:0]         x_reg, y_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic [AW-1:0]             ptr_reg;
    logic [BPT_W-1:0]          cnt_reg;
    logic [1:0]                pend_idx_reg;
    logic [BYTE_W-1:0]         rgba_reg [4];
    status_t                   status_reg;
    logic [STATUS_W-1:0]       out_status_reg;
    logic [BYTE_W-1:0]         out_red_reg, out_green_reg, out_blue_reg, out_alpha_reg;

    // Shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;

    // Store
    logic              st_wr_en;
    logic [BYTE_W-1:0] st_rd_data;

    // Derived values
    logic                      accept;
    logic                      out_load;
    logic signed [COORD_W-1:0] prod_coord;
    logic [SIZE_W-1:0]         width_eff, height_eff;
    logic [BPT_W-1:0]          bpt_eff;
    logic                      u_neg, u_big, v_neg, v_big;
    logic                      transparent;
    logic [14:0]               x_bytes;
    logic [ADDR_W-1:0]         limit;
    logic                      miss;
    logic [BPT_W-1:0]          cnt_inc;

    function automatic logic above_one(input logic signed [COORD_W-1:0] c);
        // Greater than 1.0 in Q16.32, or negative
        return c[COORD_W-1] || (|c[COORD_W-2:33]) || (c[32] && (|c[31:0]));
    endfunction

    function automatic logic [SIZE_W-1:0] axis_pick(
        input logic              neg,
        input logic              big,
        input logic [SIZE_W-1:0] hi,
        input logic [SIZE_W-1:0] size
    );
        logic [SIZE_W-1:0] idx;
        priority if (neg)
        begin
            idx = '0;
        end
        else if (big)
        begin
            idx = size - SIZE_W'(1);
        end
        else
        begin
            idx = hi;
        end
        return idx;
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uv_scale_reg  <= UV_SCALE_RST;
            mode_reg      <= MODE_RST;
            width_reg     <= WIDTH_RST;
            height_reg    <= HEIGHT_RST;
            stride_reg    <= STRIDE_RST;
            bpt_reg       <= BPT_RST;
            img_bytes_reg <= IMG_BYTES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UV_SCALE:        uv_scale_reg  <= cfg_data[POS_W-1:0];
                CFG_ADDRESS_MODE:    mode_reg      <= cfg_data[MODE_W-1:0];
                CFG_TEX_WIDTH:       width_reg     <= cfg_data[SIZE_W-1:0];
                CFG_TEX_HEIGHT:      height_reg    <= cfg_data[SIZE_W-1:0];
                CFG_ROW_STRIDE:      stride_reg    <= cfg_data[STRIDE_W-1:0];
                CFG_BYTES_PER_TEXEL: bpt_reg       <= cfg_data[BPT_W-1:0];
                CFG_IMAGE_BYTES:     img_bytes_reg <= cfg_data[IMG_W-1:0];
                default:             ;
            endcase
        end
    end

    assign accept   = item.valid && item.ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || result.ready);
    assign st_wr_en = accept && !item.op && (32'(item.write_addr) < 32'(TEX_BYTES));

    assign prod_coord = prod_reg[COORD_W-1:0];
    assign width_eff  = (width_reg == '0) ? SIZE_W'(1) : width_reg;
    assign height_eff = (height_reg == '0) ? SIZE_W'(1) : height_reg;
    assign bpt_eff    = (bpt_reg > BPT_W'(4)) ? BPT_W'(4) : bpt_reg;
    assign cnt_inc    = cnt_reg + BPT_W'(1);

    // Wrapped coordinate flags: clamp caps at the last texel, repeat keeps the fraction
    assign u_neg = (mode_reg != AM_CLAMP) && (mode_reg != AM_REPEAT) && u_reg[COORD_W-1];
    assign u_big = (mode_reg != AM_REPEAT) && !u_reg[COORD_W-1] && (|u_reg[COORD_W-2:32]);
    assign v_neg = (mode_reg != AM_CLAMP) && (mode_reg != AM_REPEAT) && v_reg[COORD_W-1];
    assign v_big = (mode_reg != AM_REPEAT) && !v_reg[COORD_W-1] && (|v_reg[COORD_W-2:32]);

    assign transparent = (mode_reg == AM_CLAMP) && (above_one(u_reg) || above_one(prod_coord));

    always_comb
    begin
        unique case (bpt_eff)
            3'd1:    x_bytes = 15'(x_reg);
            3'd2:    x_bytes = {1'b0, x_reg, 1'b0};
            3'd3:    x_bytes = 15'(x_reg) + {1'b0, x_reg, 1'b0};
            3'd4:    x_bytes = {x_reg, 2'b00};
            default: x_bytes = '0;
        endcase
    end

    assign limit = (ADDR_W'(img_bytes_reg) > ADDR_W'(TEX_BYTES)) ?
                   ADDR_W'(TEX_BYTES) : ADDR_W'(img_bytes_reg);
    assign miss  = (addr_reg + ADDR_W'(bpt_eff)) > limit;

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MUL_U:
            begin
                mul_a = MUL_A_W'(pos_u_reg);
                mul_b = uv_scale_reg;
            end
            S_MUL_V:
            begin
                mul_a = MUL_A_W'(pos_v_reg);
                mul_b = uv_scale_reg;
            end
            S_MUL_X:
            begin
                mul_a = {1'b0, u_reg[31:0]};
                mul_b = {{(MUL_B_W-SIZE_W){1'b0}}, width_eff};
            end
            S_MUL_Y:
            begin
                mul_a = {1'b0, v_reg[31:0]};
                mul_b = {{(MUL_B_W-SIZE_W){1'b0}}, height_eff};
            end
            S_MUL_ROW:
            begin
                mul_a = {{(MUL_A_W-SIZE_W){1'b0}}, y_reg};
                mul_b = {{(MUL_B_W-STRIDE_W){1'b0}}, stride_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = item.op ? S_MUL_U : S_DONE;
                end
            end
            S_MUL_U:   state_next = S_MUL_V;
            S_MUL_V:   state_next = S_MUL_X;
            S_MUL_X:   state_next = transparent ? S_DONE : S_MUL_Y;
            S_MUL_Y:   state_next = S_CAP_Y;
            S_CAP_Y:   state_next = S_MUL_ROW;
            S_MUL_ROW: state_next = S_ADDR;
            S_ADDR:    state_next = S_CHECK;
            S_CHECK:   state_next = (miss || (bpt_eff == '0)) ? S_DONE : S_READ;
            S_READ:    state_next = (cnt_inc == bpt_eff) ? S_LAST : S_READ;
            S_LAST:    state_next = S_DONE;
            S_DONE:    state_next = out_load ? S_IDLE : S_DONE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign pend_next = (state_reg == S_READ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_u_reg  <= item.pos_u;
            pos_v_reg  <= item.pos_v;
            status_reg <= item.op ? ST_FETCH : ST_WRITE;
            rgba_reg[0] <= '0;
            rgba_reg[1] <= '0;
            rgba_reg[2] <= '0;
            rgba_reg[3] <= item.op ? ALPHA_OPAQUE : '0;
        end

        if (state_reg == S_MUL_V)
        begin
            u_reg <= prod_coord;
        end

        if (state_reg == S_MUL_X)
        begin
            v_reg <= prod_coord;
            if (transparent)
            begin
                status_reg  <= ST_TRANSP;
                rgba_reg[3] <= '0;
            end
        end

        if (state_reg == S_MUL_Y)
        begin
            x_reg <= axis_pick(u_neg, u_big, prod_reg[44:32], width_eff);
        end

        if (state_reg == S_CAP_Y)
        begin
            y_reg <= axis_pick(v_neg, v_big, prod_reg[44:32], height_eff);
        end

        if (state_reg == S_ADDR)
        begin
            addr_reg <= prod_reg[ADDR_W-1:0] + ADDR_W'(x_bytes);
        end

        if (state_reg == S_CHECK)
        begin
            ptr_reg <= addr_reg[AW-1:0];
            cnt_reg <= '0;
            if (miss)
            begin
                status_reg <= ST_MISS;
            end
        end

        if (state_reg == S_READ)
        begin
            ptr_reg      <= ptr_reg + AW'(1);
            cnt_reg      <= cnt_inc;
            pend_idx_reg <= cnt_reg[1:0];
        end

        // Drop the returned byte into its channel
        if (pend_reg)
        begin
            rgba_reg[pend_idx_reg] <= st_rd_data;
        end

        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_red_reg    <= rgba_reg[0];
            out_green_reg  <= rgba_reg[1];
            out_blue_reg   <= rgba_reg[2];
            out_alpha_reg  <= rgba_reg[3];
        end
    end

    ttf_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    ttf_store #(
        .DEPTH (TEX_BYTES)
    ) u_store (
        .clk         (clk),
        .wr_en       (st_wr_en),
        .wr_addr     (AW'(item.write_addr)),
        .wr_data     (item.write_byte),
        .rd_en       (state_reg == S_READ),
        .rd_addr     (ptr_reg),
        .rd_data_reg (st_rd_data)
    );

    assign item.ready    = (state_reg == S_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.status = out_status_reg;
    assign result.red    = out_red_reg;
    assign result.green  = out_green_reg;
    assign result.blue   = out_blue_reg;
    assign result.alpha  = out_alpha_reg;

    `TTF_ASSERT_NOW(a_read_in_texel, state_reg == S_READ, cnt_reg < bpt_eff,
        "byte read issued past the texel size")
    `TTF_ASSERT_NEXT(a_write_done, accept && !item.op,
        state_reg == S_DONE && status_reg == ST_WRITE, "write beat did not go to done")
    `TTF_ASSERT_NOW(a_miss_color, result.valid && result.status == ST_MISS,
        result.red == '0 && result.green == '0 && result.blue == '0 &&
        result.alpha == ALPHA_OPAQUE, "miss beat carries texel data")
    `TTF_ASSERT_NOW(a_transp_color, result.valid && result.status == ST_TRANSP,
        result.red == '0 && result.green == '0 && result.blue == '0 &&
        result.alpha == '0, "transparent beat is not all zero")
endmodule

[sim/texel_fetch_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texel fetch checker
// Tracks the register file and the texel store from the observed write port
// and request beats, predicts one status/RGBA result per request and matches
// each result beat, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module texel_fetch_checker
    import ttf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ttf_in_if                     item,
    ttf_out_if                    result,
    output int                    fail_count,
    output int                    pending,
    output int                    n_fetch,
    output int                    n_transp,
    output int                    n_miss,
    output int                    n_write
);

    localparam longint UNIT = 64'sh1_0000_0000;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   red;
        logic [BYTE_W-1:0]   green;
        logic [BYTE_W-1:0]   blue;
        logic [BYTE_W-1:0]   alpha;
    } texel_t;

    logic signed [POS_W-1:0] uv_scale;
    logic [MODE_W-1:0]       addr_mode;
    logic [SIZE_W-1:0]       tex_width;
    logic [SIZE_W-1:0]       tex_height;
    logic [STRIDE_W-1:0]     row_stride;
    logic [BPT_W-1:0]        texel_bytes;
    logic [IMG_W-1:0]        image_bytes;

    logic [BYTE_W-1:0] texel_mem [0:TEX_BYTES_DEF-1];
    texel_t            pending_texels[$];

    // Apply the address mode to a Q16.32 coordinate.
    function automatic longint fold_coord(input longint c);
        if (addr_mode == AM_CLAMP) begin
            if (c > UNIT - 1)
                return UNIT - 1;
            if (c < 0)
                return 0;
            return c;
        end
        if (addr_mode == AM_REPEAT)
            return c & 64'h0000_0000_FFFF_FFFF;
        return c;
    endfunction

    function automatic longint unsigned texel_index(input longint c,
                                                    input logic [SIZE_W-1:0] size);
        longint unsigned n;
        longint unsigned i;
        n = (size == 0) ? 1 : size;
        if (c < 0)
            return 0;
        i = ($unsigned(c) * n) >> 32;
        if (i >= n)
            i = n - 1;
        return i;
    endfunction

    function automatic texel_t predict_texel(input logic signed [POS_W-1:0] pu,
                                             input logic signed [POS_W-1:0] pv);
        texel_t t;
        longint s;
        longint cu;
        longint cv;
        longint unsigned x;
        longint unsigned y;
        longint unsigned b;
        longint unsigned addr;
        longint unsigned lim;
        t.status = ST_FETCH;
        t.red    = '0;
        t.green  = '0;
        t.blue   = '0;
        t.alpha  = ALPHA_OPAQUE;
        s  = uv_scale;
        cu = longint'(pu) * s;
        cv = longint'(pv) * s;
        if (addr_mode == AM_CLAMP && (cu < 0 || cu > UNIT || cv < 0 || cv > UNIT)) begin
            t.status = ST_TRANSP;
            t.alpha  = '0;
            return t;
        end
        x    = texel_index(fold_coord(cu), tex_width);
        y    = texel_index(fold_coord(cv), tex_height);
        b    = (texel_bytes > 4) ? 4 : texel_bytes;
        addr = y * row_stride + x * b;
        lim  = (image_bytes > TEX_BYTES_DEF) ? TEX_BYTES_DEF : image_bytes;
        if (addr + b > lim) begin
            t.status = ST_MISS;
            return t;
        end
        if (b > 0) t.red   = texel_mem[addr];
        if (b > 1) t.green = texel_mem[addr + 1];
        if (b > 2) t.blue  = texel_mem[addr + 2];
        if (b > 3) t.alpha = texel_mem[addr + 3];
        return t;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        texel_t want;
        texel_t wr_done;
        if (!rst_n) begin
            uv_scale    = UV_SCALE_RST;
            addr_mode   = MODE_RST;
            tex_width   = WIDTH_RST;
            tex_height  = HEIGHT_RST;
            row_stride  = STRIDE_RST;
            texel_bytes = BPT_RST;
            image_bytes = IMG_BYTES_RST;
            pending_texels.delete();
            fail_count = 0;
            pending    = 0;
            n_fetch    = 0;
            n_transp   = 0;
            n_miss     = 0;
            n_write    = 0;
        end
        else begin
            if (result.valid && result.ready) begin
                if (pending_texels.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result beat with nothing outstanding: status %0d",
                                 $realtime, result.status);
                    fail_count++;
                end
                else begin
                    want = pending_texels.pop_front();
                    if (result.status !== want.status || result.red !== want.red ||
                        result.green !== want.green || result.blue !== want.blue ||
                        result.alpha !== want.alpha) begin
                        if (fail_count < 10)
                            $display("%0t: expected st %0d rgba %02h %02h %02h %02h, got st %0d rgba %02h %02h %02h %02h",
                                     $realtime, want.status, want.red, want.green, want.blue,
                                     want.alpha, result.status, result.red, result.green,
                                     result.blue, result.alpha);
                        fail_count++;
                    end
                    case (want.status)
                        ST_FETCH:  n_fetch++;
                        ST_TRANSP: n_transp++;
                        ST_MISS:   n_miss++;
                        default:   n_write++;
                    endcase
                end
            end

            if (item.valid && item.ready) begin
                if (!item.op) begin
                    // op low stores one byte; the result carries no texel
                    texel_mem[item.write_addr] = item.write_byte;
                    wr_done.status = ST_WRITE;
                    wr_done.red    = '0;
                    wr_done.green  = '0;
                    wr_done.blue   = '0;
                    wr_done.alpha  = '0;
                    pending_texels.push_back(wr_done);
                end
                else begin
                    pending_texels.push_back(predict_texel(item.pos_u, item.pos_v));
                end
            end

            if (cfg_we) begin
                case (cfg_index)
                    CFG_UV_SCALE:        uv_scale    = cfg_data[POS_W-1:0];
                    CFG_ADDRESS_MODE:    addr_mode   = cfg_data[MODE_W-1:0];
                    CFG_TEX_WIDTH:       tex_width   = cfg_data[SIZE_W-1:0];
                    CFG_TEX_HEIGHT:      tex_height  = cfg_data[SIZE_W-1:0];
                    CFG_ROW_STRIDE:      row_stride  = cfg_data[STRIDE_W-1:0];
                    CFG_BYTES_PER_TEXEL: texel_bytes = cfg_data[BPT_W-1:0];
                    CFG_IMAGE_BYTES:     image_bytes = cfg_data[IMG_W-1:0];
                    default: ;
                endcase
            end

            pending = pending_texels.size();
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texel fetch core testbench
// Programs a series of texture setups, fills the reachable part of the store,
// then streams write and sample requests with random gaps and result stalls.
// The checker beside the core predicts and matches every result beat.
// ----------------------------------------------------------------------------
module testbench;
    import ttf_pkg::*;

    localparam logic [MODE_W-1:0] AM_DIRECT    = 2'd2;
    localparam logic [MODE_W-1:0] AM_DIRECT_HI = 2'd3;
    localparam logic              OP_WRITE     = 1'b0;
    localparam logic              OP_SAMPLE    = 1'b1;
    localparam int                ITEM_TARGET  = 1900;
    localparam int                FILL_CAP     = 512;

    typedef struct {
        logic signed [POS_W-1:0] scale;
        logic [MODE_W-1:0]       mode;
        logic [SIZE_W-1:0]       width;
        logic [SIZE_W-1:0]       height;
        logic [STRIDE_W-1:0]     stride;
        logic [BPT_W-1:0]        bpt;
        logic [IMG_W-1:0]        img;
    } tex_setup_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int         fail_count;
    int         pending;
    int         n_fetch;
    int         n_transp;
    int         n_miss;
    int         n_write;
    int         sent;
    int         filled;
    int         setups;
    bit         no_idle;
    tex_setup_t setup;

    ttf_in_if  item_ch();
    ttf_out_if res_ch();

    texture_texel_fetch_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (res_ch)
    );

    texel_fetch_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item       (item_ch),
        .result     (res_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .n_fetch    (n_fetch),
        .n_transp   (n_transp),
        .n_miss     (n_miss),
        .n_write    (n_write)
    );

    always #6 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("texture_texel_fetch_core: mismatch");
        $finish;
    end

    // Result side: stall a random number of cycles before taking each beat.
    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid) @(posedge clk);
            @(negedge clk);
        end
    end

    task automatic send_item(input logic op, input logic [WADDR_W-1:0] addr,
                             input logic [BYTE_W-1:0] data,
                             input logic signed [POS_W-1:0] pu,
                             input logic signed [POS_W-1:0] pv);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.op         <= op;
        item_ch.write_addr <= addr;
        item_ch.write_byte <= data;
        item_ch.pos_u      <= pu;
        item_ch.pos_v      <= pv;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // Hold requests until every outstanding result has drained.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Highest store byte, plus one, that a fetch can touch under this setup.
    function automatic longint store_reach(input tex_setup_t c);
        longint w;
        longint h;
        longint b;
        longint geo;
        longint lim;
        w = (c.width == 0) ? 1 : c.width;
        h = (c.height == 0) ? 1 : c.height;
        b = (c.bpt > 4) ? 4 : c.bpt;
        if (b == 0)
            return 0;
        geo = (h - 1) * c.stride + w * b;
        lim = (c.img > TEX_BYTES_DEF) ? TEX_BYTES_DEF : c.img;
        return (geo < lim) ? geo : lim;
    endfunction

    task automatic load_setup(input tex_setup_t c);
        longint reach;
        // keep every fetchable byte inside the part of the store we fill
        if (store_reach(c) > FILL_CAP)
            c.img = IMG_W'($urandom_range(0, FILL_CAP));
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_UV_SCALE;
        cfg_data  <= CFG_DATA_W'(c.scale);
        @(negedge clk);
        cfg_index <= CFG_ADDRESS_MODE;
        cfg_data  <= CFG_DATA_W'(c.mode);
        @(negedge clk);
        cfg_index <= CFG_TEX_WIDTH;
        cfg_data  <= CFG_DATA_W'(c.width);
        @(negedge clk);
        cfg_index <= CFG_TEX_HEIGHT;
        cfg_data  <= CFG_DATA_W'(c.height);
        @(negedge clk);
        cfg_index <= CFG_ROW_STRIDE;
        cfg_data  <= CFG_DATA_W'(c.stride);
        @(negedge clk);
        cfg_index <= CFG_BYTES_PER_TEXEL;
        cfg_data  <= CFG_DATA_W'(c.bpt);
        @(negedge clk);
        cfg_index <= CFG_IMAGE_BYTES;
        cfg_data  <= CFG_DATA_W'(c.img);
        @(negedge clk);
        cfg_we <= 1'b0;
        setup = c;
        setups++;
        reach = store_reach(c);
        while (filled < reach)
        begin
            send_item(OP_WRITE, filled[WADDR_W-1:0], 8'($urandom), 24'($urandom),
                      24'($urandom));
            filled++;
        end
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 13'd8191;
            2:       return 13'($urandom_range(1, 4096));
            default: return 13'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic tex_setup_t random_setup();
        tex_setup_t c;
        int b;
        case ($urandom_range(0, 7))
            0:       c.scale = 24'sh800000;
            1:       c.scale = 24'sh7FFFFF;
            2:       c.scale = '0;
            3:       c.scale = 24'($urandom);
            4:       c.scale = -24'sd65536;
            5:       c.scale = 24'($urandom_range(16384, 262144));
            default: c.scale = 24'sd65536;
        endcase
        case ($urandom_range(0, 5))
            0:       c.mode = AM_DIRECT;
            1:       c.mode = AM_DIRECT_HI;
            2, 3:    c.mode = AM_REPEAT;
            default: c.mode = AM_CLAMP;
        endcase
        c.width  = pick_size();
        c.height = pick_size();
        case ($urandom_range(0, 9))
            0:       c.bpt = '0;
            1:       c.bpt = 3'($urandom_range(5, 7));
            default: c.bpt = 3'($urandom_range(1, 4));
        endcase
        b = (c.bpt > 4) ? 4 : c.bpt;
        case ($urandom_range(0, 5))
            0:       c.stride = '0;
            1:       c.stride = 16'hFFFF;
            2:       c.stride = 16'($urandom);
            default: c.stride = 16'(c.width * b + $urandom_range(0, 3));
        endcase
        case ($urandom_range(0, 4))
            0:       c.img = 17'd65536;
            1:       c.img = 17'h1FFFF;
            2:       c.img = 17'($urandom);
            default: c.img = 17'($urandom_range(0, 2048));
        endcase
        return c;
    endfunction

    function automatic longint UNIT_SPAN(input longint mag);
        longint s;
        s = (64'sh1_0000_0000 / mag) * 9 / 8;
        return (s > 24'sh7FFFFF) ? 24'sh7FFFFF : s;
    endfunction

    // Mostly coordinates that land in or just past the unit square after scaling.
    function automatic logic signed [POS_W-1:0] pick_coord(input logic signed [POS_W-1:0] scale);
        longint mag;
        longint span;
        longint p;
        case ($urandom_range(0, 9))
            0, 1:    return 24'($urandom);
            2:       return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            default:
            begin
                if (scale == 0)
                    return 24'($urandom);
                mag  = (scale < 0) ? -longint'(scale) : longint'(scale);
                span = UNIT_SPAN(mag);
                p    = $urandom_range(0, 32'(span));
                return (scale < 0) ? 24'(-p) : 24'(p);
            end
        endcase
    endfunction

    task automatic random_items(input int count);
        logic [WADDR_W-1:0] addr;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                wait_idle();
            if ($urandom_range(0, 9) < 7)
            begin
                send_item(OP_SAMPLE, 16'($urandom), 8'($urandom),
                          pick_coord(setup.scale), pick_coord(setup.scale));
            end
            else
            begin
                addr = (filled > 0 && $urandom_range(0, 1)) ?
                       16'($urandom_range(0, filled - 1)) : 16'($urandom);
                send_item(OP_WRITE, addr, 8'($urandom), 24'($urandom), 24'($urandom));
            end
        end
    endtask

    initial
    begin
        tex_setup_t fixed [0:3];
        logic signed [POS_W-1:0] dir_u [0:10];
        logic signed [POS_W-1:0] dir_v [0:10];

        fixed[0] = '{24'sd65536, AM_CLAMP, 13'd4, 13'd4, 16'd16, 3'd4, 17'd65536};
        fixed[1] = '{24'sh7FFFFF, AM_REPEAT, 13'd8191, 13'd0, 16'hFFFF, 3'd7, 17'h1FFFF};
        fixed[2] = '{24'sh800000, AM_DIRECT_HI, 13'd1, 13'd1, 16'd0, 3'd0, 17'h1FFFF};
        fixed[3] = '{24'sd0, AM_DIRECT, 13'd4096, 13'd4096, 16'd0, 3'd1, 17'd0};

        // origin, exactly one, just above one, just below zero, field extremes, interior points
        dir_u = '{24'sd0, 24'sd65536, 24'sd65537, 24'sd0, -24'sd1, 24'sd0,
                  24'sh7FFFFF, 24'sh800000, 24'sd32768, 24'sd65535, 24'sd16384};
        dir_v = '{24'sd0, 24'sd65536, 24'sd0, 24'sd65537, 24'sd0, -24'sd1,
                  24'sh7FFFFF, 24'sh800000, 24'sd49152, 24'sd1, 24'sd65535};

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        item_ch.valid      = 1'b0;
        item_ch.op         = OP_WRITE;
        item_ch.write_addr = '0;
        item_ch.write_byte = '0;
        item_ch.pos_u      = '0;
        item_ch.pos_v      = '0;
        sent    = 0;
        filled  = 0;
        setups  = 0;
        no_idle = 1'b0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        load_setup(fixed[0]);
        send_item(OP_WRITE, 16'h0000, 8'h00, 24'sh7FFFFF, 24'sh7FFFFF);
        send_item(OP_WRITE, 16'hFFFF, 8'hFF, 24'sh800000, 24'sh800000);
        send_item(OP_WRITE, 16'h5A5A, 8'hA5, 24'sd0, 24'sd0);
        send_item(OP_WRITE, 16'h0003, 8'h3C, -24'sd1, -24'sd1);
        for (int i = 0; i < 11; i++)
            send_item(OP_SAMPLE, i[0] ? 16'hFFFF : 16'h0000, i[0] ? 8'hFF : 8'h00,
                      dir_u[i], dir_v[i]);

        for (int k = 1; k < 4; k++)
        begin
            load_setup(fixed[k]);
            random_items(40);
        end

        while (sent < ITEM_TARGET)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            load_setup(random_setup());
            random_items($urandom_range(60, 160));
        end

        no_idle = 1'b0;
        wait_idle();
        repeat (20) @(negedge clk);

        $display("Ran %0d requests over %0d texture setups: %0d writes, %0d fetches,",
                 sent, setups, n_write, n_fetch);
        $display("%0d transparent clamps and %0d misses.", n_transp, n_miss);
        if (fail_count == 0 && pending == 0)
            $display("texture_texel_fetch_core: match");
        else
            $display("texture_texel_fetch_core: mismatch");
        $finish;
    end

endmodule
